@@ sv/crf_pkg.sv @@
package crf_pkg;

  localparam int QDepth = 2;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [7:0]  ErrFlag = 8'h80;
  localparam logic [7:0]  AddrReset = 8'h01;

  typedef struct packed {
    logic       is_err;
    logic [7:0] cmd;
    logic [7:0] ecode;
  } crf_req_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CMD   = 5'b00010,
    ST_ECODE = 5'b00100,
    ST_CRCLO = 5'b01000,
    ST_CRCHI = 5'b10000
  } crf_step_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ sv/crf_front.sv @@
module crf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,   // command [7:0], error_code [15:8]
  input  logic              in_tuser,   // opcode
  output logic              req_valid,
  input  logic              req_ready,
  output crf_pkg::crf_req_t req
);

  localparam int PtrW = (crf_pkg::QDepth > 1) ? $clog2(crf_pkg::QDepth) : 1;
  localparam int CntW = $clog2(crf_pkg::QDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(crf_pkg::QDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(crf_pkg::QDepth);

  crf_pkg::crf_req_t mem_r [crf_pkg::QDepth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  crf_pkg::crf_req_t entry;
  logic push, pop;

  always_comb begin
    entry.is_err = in_tuser;
    entry.cmd    = in_tdata[7:0] | (in_tuser ? crf_pkg::ErrFlag : 8'h00);
    entry.ecode  = in_tdata[15:8];
  end

  assign in_tready = (cnt_r != CntFull);
  assign req_valid = (cnt_r != '0);
  assign req       = mem_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = req_valid && req_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= entry;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntFull) else $error("queue count exceeds depth");
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1)) else $error("push lost");
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (cnt_r == $past(cnt_r) - 1'b1)) else $error("pop lost");
`endif

endmodule

@@ sv/crf_back.sv @@
module crf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        device_address,
  input  logic              req_valid,
  output logic              req_ready,
  input  crf_pkg::crf_req_t req,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,   // tx_byte
  output logic              out_tlast    // last
);

  crf_pkg::crf_step_t state_r, state_nxt;
  crf_pkg::crf_req_t  req_r;
  logic [15:0]        crc_r, crc_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_data_r, out_data_nxt;
  logic               out_last_r, out_last_nxt;
  logic               adv;
  logic [15:0]        crc_in;
  logic [7:0]         crc_b;

  assign adv       = !out_valid_r || out_tready;
  assign req_ready = adv && (state_r == crf_pkg::ST_IDLE);

  always_comb begin
    crc_in = crc_r;
    crc_b  = req_r.cmd;
    case (state_r)
      crf_pkg::ST_IDLE: begin
        crc_in = crf_pkg::CrcInit;
        crc_b  = device_address;
      end
      crf_pkg::ST_ECODE: crc_b = req_r.ecode;
      default: crc_b = req_r.cmd;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (adv) begin
      case (state_r)
        crf_pkg::ST_IDLE: begin
          if (req_valid) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = device_address;
            out_last_nxt  = 1'b0;
            crc_nxt       = crf_pkg::crc_byte(crc_in, crc_b);
            state_nxt     = crf_pkg::ST_CMD;
          end
        end
        crf_pkg::ST_CMD: begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = req_r.cmd;
          out_last_nxt  = 1'b0;
          crc_nxt       = crf_pkg::crc_byte(crc_in, crc_b);
          state_nxt     = req_r.is_err ? crf_pkg::ST_ECODE : crf_pkg::ST_CRCLO;
        end
        crf_pkg::ST_ECODE: begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = req_r.ecode;
          out_last_nxt  = 1'b0;
          crc_nxt       = crf_pkg::crc_byte(crc_in, crc_b);
          state_nxt     = crf_pkg::ST_CRCLO;
        end
        crf_pkg::ST_CRCLO: begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = crc_r[7:0];
          out_last_nxt  = 1'b0;
          state_nxt     = crf_pkg::ST_CRCHI;
        end
        crf_pkg::ST_CRCHI: begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = crc_r[15:8];
          out_last_nxt  = 1'b1;
          state_nxt     = crf_pkg::ST_IDLE;
        end
        default: state_nxt = crf_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= crf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r      <= crc_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    if (req_valid && req_ready) begin
      req_r <= req;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    (req_valid && req_ready) |=> (out_valid_r && !out_last_r
      && state_r == crf_pkg::ST_CMD)) else $error("frame did not start");
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && state_r == crf_pkg::ST_CRCHI) |=> (out_valid_r && out_last_r
      && state_r == crf_pkg::ST_IDLE)) else $error("frame did not end");
  a_ecode_err: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == crf_pkg::ST_ECODE) |-> req_r.is_err) else $error("error byte in ok reply");
`endif

endmodule

@@ sv/crc16_reply_framer.sv @@
// Channel  Direction  Payload
// in_      input      tdata: command [7:0], error_code [15:8]; tuser: opcode
// out_     output     tdata: tx_byte [7:0]; tlast: last
// cfg_     input      data: device_address [7:0]
//
// One reply byte leaves per cycle unless stalled: an ok reply is 4 bytes, an error reply 5.
// The byte sequencer in the back part sets that rate; a two-entry request queue
// lets new requests be taken while a frame is still going out.
// Reset (synchronous, rst_n low) empties the queue, idles the sequencer and sets
// the device address to 1. A stalled output holds its byte and the sequencer waits.
module crc16_reply_framer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // command [7:0], error_code [15:8]
  input  logic        in_tuser,    // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // tx_byte
  output logic        out_tlast,   // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic [7:0]        device_address_r;
  crf_pkg::crf_req_t req;
  logic              req_valid;
  logic              req_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_address_r <= crf_pkg::AddrReset;
    end else if (cfg_valid && cfg_ready) begin
      device_address_r <= cfg_data;
    end
  end

  crf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req)
  );

  crf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .device_address (device_address_r),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req            (req),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast)
  );

endmodule
